// ===== hw/rtl/mqub_pkg.sv =====
package mqub_pkg;

    localparam int unsigned COUNT_W = 28;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [2:0] {
        PH_ID   = 3'd0,
        PH_LEN  = 3'd1,
        PH_VAL  = 3'd2,
        PH_DONE = 3'd3,
        PH_ERR  = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        K_NONE  = 3'd0,
        K_ID    = 3'd1,
        K_TOPIC = 3'd2,
        K_ERR   = 3'd3,
        K_LEFT  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        E_NONE       = 2'd0,
        E_NO_PAYLOAD = 2'd1,
        E_ZERO_LEN   = 2'd2,
        E_OVERFLOW   = 2'd3
    } err_t;

    typedef struct packed {
        phase_t             phase;
        logic [COUNT_W-1:0] consumed;
        logic               field_cnt;
        logic [7:0]         high_hold;
        logic [15:0]        topic_left;
        logic [15:0]        packet_id;
        err_t               err;
    } state_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] packet_id;
        logic [7:0]  topic_byte;
        logic        topic_last;
        logic        packet_done;
        err_t        error_code;
    } result_t;

    localparam state_t STATE_CLEAR = '{
        phase:      PH_ID,
        consumed:   '0,
        field_cnt:  1'b0,
        high_hold:  8'd0,
        topic_left: 16'd0,
        packet_id:  16'd0,
        err:        E_NONE
    };

endpackage

// ===== hw/rtl/mqtt_unsubscribe_body_parser.sv =====
// Parser for the variable part of an MQTT UNSUBSCRIBE packet. Each input request carries one
// body byte (s_tdata) and a restart flag (s_tuser) that clears the parser before that byte is
// taken; cfg_wdata sets the remaining length of the body; the user must write it only while
// the block is idle, and the block does not enforce this. Every input request yields exactly
// one result request: a kind code, the packet identifier seen so far, the topic byte with its
// last-byte marker, a body-complete flag and a latched error code. The block takes one byte
// per clock cycle, back to back, while the output is not stalled; results sit in a single
// result register, and a new byte is taken whenever it is empty or is being read in the same
// cycle. Errors hold until a restart, and bytes after a complete body are reported as leftover.
module mqtt_unsubscribe_body_parser (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [27:0] cfg_wdata,   // body_length

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] data_byte
    input  logic [0:0]  s_tuser,     // [0] restart

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [15:0] packet_id, [23:16] topic_byte,
                                     // [25:24] error_code, [31:26] zero
    output logic [3:0]  m_tuser,     // [2:0] kind, [3] packet_done
    output logic        m_tlast      // topic_last
);
    import mqub_pkg::*;

    logic [COUNT_W-1:0] body_length_reg;
    state_t             state_reg;
    state_t             state_next;
    result_t            res_next;
    result_t            out_reg;
    logic               out_valid_reg;
    logic               in_accept;

    // The result register may be refilled in the same cycle it is drained.
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    mqub_core u_core (
        .cur         (state_reg),
        .data_byte   (s_tdata),
        .restart     (s_tuser[0]),
        .body_length (body_length_reg),
        .nxt         (state_next),
        .res         (res_next)
    );

    // Configuration and parser state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            body_length_reg <= '0;
            state_reg       <= STATE_CLEAR;
        end else begin
            if (cfg_we) begin
                body_length_reg <= cfg_wdata;
            end
            if (in_accept) begin
                state_reg <= state_next;
            end
        end
    end

    // Result register: only the valid flag is reset, the payload is loaded on acceptance.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            out_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.error_code, out_reg.topic_byte, out_reg.packet_id};
    assign m_tuser  = {out_reg.packet_done, out_reg.kind};
    assign m_tlast  = out_reg.topic_last;

    // A completed body always closes a topic.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3] |-> m_tlast && (m_tuser[2:0] == K_TOPIC))
        else $error("packet_done without a final topic byte");

    // The error code is shown only with an error result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[25:24] != E_NONE) |-> (m_tuser[2:0] == K_ERR))
        else $error("error code outside an error result");

    // The error phase always carries a latched cause.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase == PH_ERR) |-> (state_reg.err != E_NONE))
        else $error("error phase without an error code");

    // Completion and error hold until a restart.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && !s_tuser[0] && (state_reg.phase == PH_DONE || state_reg.phase == PH_ERR)
        |=> (state_reg.phase == $past(state_reg.phase)))
        else $error("terminal phase left without restart");

    // A result follows every accepted byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> m_tvalid)
        else $error("accepted byte produced no result");

endmodule

// ===== hw/rtl/mqub_core.sv =====
module mqub_core (
    input  mqub_pkg::state_t                  cur,
    input  logic [7:0]                        data_byte,
    input  logic                              restart,
    input  logic [mqub_pkg::COUNT_W-1:0]      body_length,
    output mqub_pkg::state_t                  nxt,
    output mqub_pkg::result_t                 res
);
    import mqub_pkg::*;

    state_t             base;
    logic [COUNT_W-1:0] cnt_inc;
    logic               at_end;
    logic [15:0]        field_word;
    logic [15:0]        left_dec;
    kind_t              kind;
    logic               tlast;
    logic               done;

    // Restart clears the parser before the byte is taken.
    assign base       = restart ? STATE_CLEAR : cur;
    assign cnt_inc    = (base.consumed != COUNT_MAX) ? base.consumed + 1'b1 : base.consumed;
    assign at_end     = (cnt_inc >= body_length);
    assign field_word = {base.high_hold, data_byte};
    assign left_dec   = (base.topic_left != 16'd0) ? base.topic_left - 16'd1 : 16'd0;

    // Next state.
    always_comb begin
        nxt = base;
        case (base.phase)
            PH_ID: begin
                nxt.consumed = cnt_inc;
                if (!base.field_cnt) begin
                    nxt.high_hold = data_byte;
                    nxt.field_cnt = 1'b1;
                end else begin
                    nxt.field_cnt = 1'b0;
                    nxt.packet_id = field_word;
                    if (at_end) begin
                        nxt.err   = E_NO_PAYLOAD;
                        nxt.phase = PH_ERR;
                    end else begin
                        nxt.phase = PH_LEN;
                    end
                end
            end
            PH_LEN: begin
                nxt.consumed = cnt_inc;
                if (!base.field_cnt) begin
                    nxt.high_hold = data_byte;
                    nxt.field_cnt = 1'b1;
                end else begin
                    nxt.field_cnt = 1'b0;
                    if (field_word == 16'd0) begin
                        nxt.err   = E_ZERO_LEN;
                        nxt.phase = PH_ERR;
                    end else if (at_end) begin
                        nxt.err   = E_OVERFLOW;
                        nxt.phase = PH_ERR;
                    end else begin
                        nxt.topic_left = field_word;
                        nxt.phase      = PH_VAL;
                    end
                end
            end
            PH_VAL: begin
                nxt.consumed   = cnt_inc;
                nxt.topic_left = left_dec;
                if (left_dec == 16'd0) begin
                    if (at_end) begin
                        nxt.phase = PH_DONE;
                    end else begin
                        nxt.phase     = PH_LEN;
                        nxt.field_cnt = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Result fields.
    always_comb begin
        kind  = K_NONE;
        tlast = 1'b0;
        done  = 1'b0;
        case (base.phase)
            PH_ID: begin
                if (base.field_cnt) begin
                    kind = at_end ? K_ERR : K_ID;
                end
            end
            PH_LEN: begin
                if (base.field_cnt && (field_word == 16'd0 || at_end)) begin
                    kind = K_ERR;
                end
            end
            PH_VAL: begin
                kind = K_TOPIC;
                if (left_dec == 16'd0) begin
                    tlast = 1'b1;
                    done  = at_end;
                end
            end
            PH_ERR: begin
                kind = K_ERR;
            end
            default: begin
                kind = K_LEFT;
            end
        endcase
        res.kind        = kind;
        res.packet_id   = nxt.packet_id;
        res.topic_byte  = (kind == K_TOPIC) ? data_byte : 8'd0;
        res.topic_last  = tlast;
        res.packet_done = done;
        res.error_code  = (kind == K_ERR) ? nxt.err : E_NONE;
    end

endmodule
